[hw/rtl/rtac_pkg.sv]
// ----------------------------------------------------------------------------
// rtac_pkg
// Shared types and constants of the relay timer and auto-off controller.
// ----------------------------------------------------------------------------
`default_nettype none

package rtac_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int CFG_AW          = 3;
  localparam int CFG_DW          = 32;

  localparam logic [7:0] CLICK_LEVEL = 8'd255;
  localparam int         ARMED_BIT   = 7;

  // register indexes
  localparam logic REG_THRESHOLD  = 1'b0;
  localparam logic REG_LOW_CYCLES = 1'b1;

  typedef enum logic [2:0] {
    MODE_CLICK  = 3'd0,
    MODE_HOLD   = 3'd1,
    MODE_TICK   = 3'd2,
    MODE_CHECK  = 3'd3,
    MODE_REMOTE = 3'd4,
    MODE_SLOT   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    CAUSE_NONE   = 3'd0,
    CAUSE_BUTTON = 3'd1,
    CAUSE_REMOTE = 3'd2,
    CAUSE_TIMER  = 3'd3,
    CAUSE_AUTO   = 3'd4
  } cause_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_EXEC = 2'd2
  } state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] current_ma;
    logic [2:0]  weekday;
    logic [7:0]  hour_in;
    logic [7:0]  minute_in;
    logic        switch_on;
    logic [7:0]  level_in;
    logic [3:0]  slot_index;
    logic [7:0]  slot_days;
    logic        slot_turn_on;
  } in_item_t;

  typedef struct packed {
    logic       relay_on;
    logic [7:0] level_out;
    logic [2:0] cause;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic mark_hit;
    logic commit;
  } rtac_cmd_t;

  typedef struct packed {
    logic in_check;
    logic match;
    logic last;
    logic out_free;
  } rtac_sts_t;

  // hour mod 24: reciprocal estimate, then one correction
  function automatic logic [4:0] mod24(input logic [7:0] v);
    logic [11:0] prod;
    logic [7:0]  q;
    logic [7:0]  r;
    prod = {4'd0, v} * 12'd10;
    q    = {4'd0, prod[11:8]};
    r    = v - 8'(q * 8'd24);
    if (r >= 8'd24) begin
      r = r - 8'd24;
    end
    return r[4:0];
  endfunction

  // minute mod 60: reciprocal estimate, then one correction
  function automatic logic [5:0] mod60(input logic [7:0] v);
    logic [12:0] prod;
    logic [7:0]  q;
    logic [7:0]  r;
    prod = {5'd0, v} * 13'd17;
    q    = {5'd0, prod[12:10]};
    r    = v - 8'(q * 8'd60);
    if (r >= 8'd60) begin
      r = r - 8'd60;
    end
    return r[5:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/rtac_ctrl.sv]
// ----------------------------------------------------------------------------
// rtac_ctrl
// Sequencer: accepts an item, steps the timer scan, commits the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rtac_ctrl
  import rtac_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire rtac_sts_t sts,
  output rtac_cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.in_check ? ST_SCAN : ST_EXEC;
        end
      end
      ST_SCAN: begin
        if (sts.match) begin
          cmd.mark_hit = 1'b1;
          state_nxt    = ST_EXEC;
        end else if (sts.last) begin
          state_nxt = ST_EXEC;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/rtac_dp.sv]
// ----------------------------------------------------------------------------
// rtac_dp
// Datapath: relay state, timer table, auto-off counter, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtac_dp
  import rtac_pkg::*;
#(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire in_item_t          in_data,
  input  wire rtac_cmd_t         cmd,
  output rtac_sts_t              sts,
  input  wire logic              cfg_we,
  input  wire logic              cfg_sel,
  input  wire logic [15:0]       cfg_wdata,
  output logic [15:0]            cfg_rdata,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data
);

  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  logic [15:0] threshold_r;
  logic [15:0] low_cycles_r;

  in_item_t    item_r;
  logic        relay_r;
  logic [7:0]  level_r;
  logic [15:0] low_count_r;
  logic [SLOT_W-1:0] idx_r;
  logic        hit_r;

  logic [7:0]  days_r   [TIMER_SLOTS];
  logic        target_r [TIMER_SLOTS];
  logic [4:0]  hour_r   [TIMER_SLOTS];
  logic [5:0]  minute_r [TIMER_SLOTS];

  logic        out_valid_r;
  out_item_t   out_data_r;

  logic        relay_nxt;
  logic [7:0]  level_nxt;
  logic [15:0] low_count_nxt;
  cause_t      cause_nxt;
  logic        day_hit;
  logic [5:0]  slot_ext;
  logic        slot_ok;
  logic [SLOT_W-1:0] wr_idx;
  logic [4:0]  wr_hour;
  logic [5:0]  wr_minute;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= '0;
      low_cycles_r <= '0;
    end else if (cfg_we) begin
      if (cfg_sel == REG_THRESHOLD) begin
        threshold_r <= cfg_wdata;
      end else begin
        low_cycles_r <= cfg_wdata;
      end
    end
  end

  assign cfg_rdata = (cfg_sel == REG_THRESHOLD) ? threshold_r : low_cycles_r;

  // scan of the current slot
  assign day_hit = (item_r.weekday <= 3'd6) && days_r[idx_r][item_r.weekday];

  assign sts.in_check = (mode_t'(in_data.mode) == MODE_CHECK);
  assign sts.match    = days_r[idx_r][ARMED_BIT] && day_hit &&
                        ({3'd0, hour_r[idx_r]} == item_r.hour_in) &&
                        ({2'd0, minute_r[idx_r]} == item_r.minute_in) &&
                        (target_r[idx_r] != relay_r);
  assign sts.last     = (idx_r == SLOT_W'(TIMER_SLOTS - 1));
  assign sts.out_free = !out_valid_r || !out_stall;

  assign slot_ext  = {2'd0, item_r.slot_index};
  assign slot_ok   = (slot_ext < 6'(TIMER_SLOTS));
  assign wr_idx    = slot_ext[SLOT_W-1:0];
  assign wr_hour   = mod24(item_r.hour_in);
  assign wr_minute = mod60(item_r.minute_in);

  // result of the held item
  always_comb begin
    relay_nxt     = relay_r;
    level_nxt     = level_r;
    low_count_nxt = low_count_r;
    cause_nxt     = CAUSE_NONE;
    case (mode_t'(item_r.mode))
      MODE_CLICK: begin
        relay_nxt = !relay_r;
        level_nxt = CLICK_LEVEL;
        cause_nxt = CAUSE_BUTTON;
      end
      MODE_TICK: begin
        low_count_nxt = '0;
        if (relay_r && (threshold_r != '0) && (low_cycles_r != '0) &&
            (item_r.current_ma < threshold_r)) begin
          if (low_count_r >= low_cycles_r) begin
            relay_nxt = 1'b0;
            level_nxt = CLICK_LEVEL;
            cause_nxt = CAUSE_AUTO;
          end else begin
            low_count_nxt = low_count_r + 16'd1;
          end
        end
      end
      MODE_CHECK: begin
        if (hit_r) begin
          relay_nxt = !relay_r;
          level_nxt = CLICK_LEVEL;
          cause_nxt = CAUSE_TIMER;
        end
      end
      MODE_REMOTE: begin
        relay_nxt = item_r.switch_on;
        level_nxt = item_r.level_in;
        cause_nxt = CAUSE_REMOTE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_r     <= 1'b0;
      level_r     <= '0;
      low_count_r <= '0;
      idx_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        days_r[i]   <= '0;
        target_r[i] <= 1'b0;
        hour_r[i]   <= '0;
        minute_r[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        idx_r <= '0;
        hit_r <= 1'b0;
      end else if (cmd.scan_step) begin
        idx_r <= idx_r + SLOT_W'(1);
      end
      if (cmd.mark_hit) begin
        hit_r <= 1'b1;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.commit) begin
        relay_r     <= relay_nxt;
        level_r     <= level_nxt;
        low_count_r <= low_count_nxt;
        out_valid_r <= 1'b1;
        if (mode_t'(item_r.mode) == MODE_HOLD) begin
          for (int i = 0; i < TIMER_SLOTS; i++) begin
            days_r[i][ARMED_BIT] <= 1'b0;
          end
        end
        if ((mode_t'(item_r.mode) == MODE_SLOT) && slot_ok) begin
          days_r[wr_idx]   <= item_r.slot_days;
          target_r[wr_idx] <= item_r.slot_turn_on;
          hour_r[wr_idx]   <= wr_hour;
          minute_r[wr_idx] <= wr_minute;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r.relay_on  <= relay_nxt;
      out_data_r.level_out <= relay_nxt ? level_nxt : 8'd0;
      out_data_r.cause     <= cause_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[hw/rtl/relay_timer_autooff_controller.sv]
// ----------------------------------------------------------------------------
// relay_timer_autooff_controller
// Relay control with weekly switch timers and low-current auto-off.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_item_t
//   out_     output     out_valid / out_stall out_item_t
//   cfg_     input      APB write/read        threshold, low cycles
//
// Each item is accepted, then committed; a minute check adds a scan of the
// timer table in between, one slot per cycle, to the first match or last slot.
// The next item is accepted while a finished result waits in the output
// register; commit holds only while that register is full and stalled.
// Reset (rst_n low, synchronous) clears relay state, counter and table.
// ----------------------------------------------------------------------------
`default_nettype none

module relay_timer_autooff_controller
  import rtac_pkg::*;
#(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  rtac_cmd_t   cmd;
  rtac_sts_t   sts;
  logic        cfg_we;
  logic [15:0] cfg_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = {16'd0, cfg_rdata};

  rtac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rtac_dp #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_sel   (cfg_paddr[2]),
    .cfg_wdata (cfg_pwdata[15:0]),
    .cfg_rdata (cfg_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the relay timer and auto-off controller.
//
// Drives events on the input channel with random gaps and takes results with
// random stalls, including one long receiver hold-off that backs up the block.
// A predictor tracks relay state, dim level, low-current run and the weekly
// timer table, and every result is compared field by field, in order, with
// the predicted one. The auto-off registers are written over the APB port
// while the block is idle, and the run steps through several settings.
// ----------------------------------------------------------------------------

module tb;
  import rtac_pkg::*;

  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam int         TX_IDLE     = 7;
  localparam int         RX_IDLE     = 7;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // predictor state
  logic        pred_on;
  logic [7:0]  pred_level;
  logic [15:0] pred_low_run;
  logic [7:0]  tmr_days   [TIMER_SLOTS_DEF];
  logic        tmr_target [TIMER_SLOTS_DEF];
  logic [4:0]  tmr_hour   [TIMER_SLOTS_DEF];
  logic [5:0]  tmr_min    [TIMER_SLOTS_DEF];
  logic [15:0] cur_threshold;
  logic [15:0] cur_low_cycles;

  out_item_t   expected_status_q [$];
  int          mismatches = 0;
  int unsigned tx_idle_max = TX_IDLE;
  int unsigned rx_idle_max = RX_IDLE;
  int unsigned rx_wait = 0;
  int unsigned holdoff_len = 0;
  logic        rx_blocked = 1'b0;

  relay_timer_autooff_controller u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    $display("ERROR %0t: %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  function automatic out_item_t predict_relay_result(input in_item_t it);
    out_item_t  r;
    cause_t     why;
    logic [7:0] daybit;
    bit         fired;
    why = CAUSE_NONE;
    case (it.mode)
      MODE_CLICK: begin
        pred_on    = ~pred_on;
        pred_level = CLICK_LEVEL;
        why        = CAUSE_BUTTON;
      end
      MODE_HOLD: begin
        for (int i = 0; i < TIMER_SLOTS_DEF; i++) tmr_days[i][ARMED_BIT] = 1'b0;
      end
      MODE_TICK: begin
        if (pred_on && cur_threshold != 0 && cur_low_cycles != 0) begin
          if (it.current_ma < cur_threshold) begin
            if (pred_low_run >= cur_low_cycles) begin
              pred_on      = 1'b0;
              pred_level   = CLICK_LEVEL;
              pred_low_run = '0;
              why          = CAUSE_AUTO;
            end else begin
              pred_low_run = pred_low_run + 16'd1;
            end
          end else begin
            pred_low_run = '0;
          end
        end else begin
          pred_low_run = '0;
        end
      end
      MODE_CHECK: begin
        if (it.weekday <= 3'd6) begin
          daybit = 8'd1 << it.weekday;
          fired  = 1'b0;
          for (int i = 0; i < TIMER_SLOTS_DEF; i++) begin
            if (!fired && tmr_days[i][ARMED_BIT] && (tmr_days[i] & daybit) != 0 &&
                {3'd0, tmr_hour[i]} == it.hour_in && {2'd0, tmr_min[i]} == it.minute_in &&
                tmr_target[i] != pred_on) begin
              fired      = 1'b1;
              pred_on    = ~pred_on;
              pred_level = CLICK_LEVEL;
              why        = CAUSE_TIMER;
            end
          end
        end
      end
      MODE_REMOTE: begin
        pred_on    = it.switch_on;
        pred_level = it.level_in;
        why        = CAUSE_REMOTE;
      end
      MODE_SLOT: begin
        if (it.slot_index < TIMER_SLOTS_DEF) begin
          tmr_days[it.slot_index]   = it.slot_days;
          tmr_target[it.slot_index] = it.slot_turn_on;
          tmr_hour[it.slot_index]   = 5'(it.hour_in % 8'd24);
          tmr_min[it.slot_index]    = 6'(it.minute_in % 8'd60);
        end
      end
      default: ;
    endcase
    r.relay_on  = pred_on;
    r.level_out = pred_on ? pred_level : 8'd0;
    r.cause     = why;
    return r;
  endfunction

  function automatic in_item_t make_item(input logic [2:0] m);
    in_item_t   it;
    logic [63:0] bits;
    bits    = {$urandom, $urandom};
    it      = bits[$bits(in_item_t)-1:0];
    it.mode = m;
    return it;
  endfunction

  function automatic in_item_t rand_event();
    in_item_t    it;
    int unsigned pick;
    int unsigned s;
    int unsigned d;
    bit          found;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      it = make_item(MODE_CLICK);
    end else if (pick < 11) begin
      it = make_item(MODE_HOLD);
    end else if (pick < 40) begin
      it = make_item(MODE_TICK);
      if (cur_threshold != 0 && $urandom_range(0, 9) < 6) begin
        it.current_ma = 16'($urandom_range(0, cur_threshold - 1));
      end else if ($urandom_range(0, 1) == 1) begin
        it.current_ma = 16'($urandom_range(cur_threshold, 16'hFFFF));
      end
    end else if (pick < 65) begin
      it = make_item(MODE_CHECK);
      if ($urandom_range(0, 9) < 7) begin
        s            = $urandom_range(0, TIMER_SLOTS_DEF - 1);
        it.hour_in   = {3'd0, tmr_hour[s]};
        it.minute_in = {2'd0, tmr_min[s]};
        d            = $urandom_range(0, 6);
        found        = 1'b0;
        for (int k = 0; k < 7; k++) begin
          if (!found && tmr_days[s][(d + k) % 7]) begin
            found      = 1'b1;
            it.weekday = 3'((d + k) % 7);
          end
        end
      end
    end else if (pick < 78) begin
      it = make_item(MODE_REMOTE);
      it.switch_on = ($urandom_range(0, 3) != 0);
    end else if (pick < 96) begin
      it = make_item(MODE_SLOT);
      if ($urandom_range(0, 4) != 0) it.slot_days[ARMED_BIT] = 1'b1;
      if ($urandom_range(0, 4) != 0) begin
        it.hour_in   = 8'($urandom_range(0, 23));
        it.minute_in = 8'($urandom_range(0, 59));
      end
    end else begin
      it = make_item(($urandom_range(0, 1) == 1) ? MODE_SPARE6 : MODE_SPARE7);
    end
    return it;
  endfunction

  // leaves in_valid high; the next send or settle takes it from there
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    expected_status_q.push_back(predict_relay_result(it));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    wait (expected_status_q.size() == 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == REG_THRESHOLD) cur_threshold = value;
    else cur_low_cycles = value;
    @(posedge clk);
  endtask

  task automatic set_auto_off(input logic [15:0] thr, input logic [15:0] lowc);
    settle();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_LOW_CYCLES, lowc);
  endtask

  task automatic send_remote(input logic on, input logic [7:0] lvl);
    in_item_t it;
    it           = make_item(MODE_REMOTE);
    it.switch_on = on;
    it.level_in  = lvl;
    send_item(it);
  endtask

  task automatic send_slot(input logic [3:0] idx, input logic [7:0] hr, input logic [7:0] mn,
                           input logic [7:0] days, input logic tgt);
    in_item_t it;
    it              = make_item(MODE_SLOT);
    it.slot_index   = idx;
    it.hour_in      = hr;
    it.minute_in    = mn;
    it.slot_days    = days;
    it.slot_turn_on = tgt;
    send_item(it);
  endtask

  task automatic send_check(input logic [2:0] wd, input logic [7:0] hr, input logic [7:0] mn);
    in_item_t it;
    it           = make_item(MODE_CHECK);
    it.weekday   = wd;
    it.hour_in   = hr;
    it.minute_in = mn;
    send_item(it);
  endtask

  task automatic send_tick(input logic [15:0] ma);
    in_item_t it;
    it            = make_item(MODE_TICK);
    it.current_ma = ma;
    send_item(it);
  endtask

  task automatic test_buttons_and_remote();
    send_item(make_item(MODE_CLICK));
    send_item(make_item(MODE_CLICK));
    send_remote(1'b1, 8'd0);
    send_remote(1'b1, 8'hFF);
    send_remote(1'b0, 8'd77);
    send_remote(1'b0, 8'd77);
    send_item(make_item(MODE_SPARE6));
    send_item(make_item(MODE_SPARE7));
    send_item(make_item(MODE_HOLD));
  endtask

  task automatic test_timer_slots();
    send_slot(4'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_slot(4'd15, 8'd23, 8'd59, 8'h81, 1'b0);
    send_slot(4'd1, 8'd24, 8'd60, 8'h7F, 1'b1);
    send_check(3'd7, 8'd15, 8'd15);
    send_check(3'd1, 8'd15, 8'd15);
    send_check(3'd0, 8'd23, 8'd59);
    send_check(3'd3, 8'd0, 8'd0);
    send_check(3'd2, 8'd200, 8'd200);
    send_item(make_item(MODE_HOLD));
    send_check(3'd1, 8'd15, 8'd15);
  endtask

  task automatic test_auto_off();
    set_auto_off(16'd100, 16'd2);
    send_remote(1'b1, 8'd9);
    send_tick(16'd99);
    send_tick(16'd100);
    send_tick(16'd0);
    send_tick(16'd0);
    send_tick(16'd0);
    send_tick(16'd0);
  endtask

  task automatic test_backpressure();
    settle();
    tx_idle_max = 0;
    rx_idle_max = RX_IDLE;
    holdoff_len = 300;
    for (int n = 0; n < 40; n++) send_item(rand_event());
    settle();
  endtask

  task automatic test_random_traffic();
    logic [15:0] thr;
    logic [15:0] lowc;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       begin thr = 16'd0;     lowc = 16'd0;     end
        1:       begin thr = 16'hFFFF;  lowc = 16'hFFFF;  end
        2:       begin thr = 16'd1;     lowc = 16'd1;     end
        3:       begin thr = 16'd300;   lowc = 16'd3;     end
        4:       begin thr = 16'hFFFF;  lowc = 16'd2;     end
        default: begin
          thr  = 16'($urandom_range(1, 2000));
          lowc = 16'($urandom_range(1, 8));
        end
      endcase
      set_auto_off(thr, lowc);
      for (int n = 0; n < 210; n++) begin
        if (n % 50 == 0) begin
          tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : TX_IDLE;
          rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : RX_IDLE;
        end
        send_item(rand_event());
      end
    end
    settle();
  endtask

  always @(posedge clk) begin : rx_side
    out_item_t   want;
    int unsigned w;
    w = rx_wait;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status_q.size() == 0) begin
        report_mismatch("result with none pending", 32'd0, 32'(out_data));
      end else begin
        want = expected_status_q.pop_front();
        if (out_data.relay_on !== want.relay_on)
          report_mismatch("relay_on", 32'(want.relay_on), 32'(out_data.relay_on));
        if (out_data.level_out !== want.level_out)
          report_mismatch("level_out", 32'(want.level_out), 32'(out_data.level_out));
        if (out_data.cause !== want.cause)
          report_mismatch("cause", 32'(want.cause), 32'(out_data.cause));
      end
      w = $urandom_range(0, rx_idle_max);
    end else if (out_valid && w != 0) begin
      w = w - 1;
    end
    rx_wait   = w;
    out_stall <= (w != 0) || rx_blocked;
  end

  initial begin : rx_holdoff
    forever begin
      wait (holdoff_len != 0);
      rx_blocked <= 1'b1;
      repeat (holdoff_len) @(posedge clk);
      rx_blocked <= 1'b0;
      holdoff_len = 0;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    pred_on        = 1'b0;
    pred_level     = '0;
    pred_low_run   = '0;
    cur_threshold  = '0;
    cur_low_cycles = '0;
    for (int i = 0; i < TIMER_SLOTS_DEF; i++) begin
      tmr_days[i]   = '0;
      tmr_target[i] = 1'b0;
      tmr_hour[i]   = '0;
      tmr_min[i]    = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_buttons_and_remote();
    test_timer_slots();
    test_auto_off();
    test_backpressure();
    test_random_traffic();

    settle();
    repeat (TIMER_SLOTS_DEF + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[relay_timer_autooff_controller.f]
hw/rtl/rtac_pkg.sv
hw/rtl/rtac_ctrl.sv
hw/rtl/rtac_dp.sv
hw/rtl/relay_timer_autooff_controller.sv
verif/tb.sv
